/* design/acpu_pkg.sv */
// Shared definitions for the accumulator CPU execute core: opcodes,
// architectural state and stack write types, instruction length helper.
// No dependencies.
`timescale 1ns / 1ps

package acpu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);

  localparam logic [2:0] SKIP_BYTES = 3'd3;

  // Opcodes
  localparam logic [7:0] OP_QUIT    = 8'd0;
  localparam logic [7:0] OP_EQUIT   = 8'd1;
  localparam logic [7:0] OP_JUMP    = 8'd2;
  localparam logic [7:0] OP_CALL    = 8'd3;
  localparam logic [7:0] OP_ABORT   = 8'd4;
  localparam logic [7:0] OP_RET     = 8'd5;
  localparam logic [7:0] OP_SETX    = 8'd6;
  localparam logic [7:0] OP_ADDIX   = 8'd7;
  localparam logic [7:0] OP_SUBIX   = 8'd8;
  localparam logic [7:0] OP_WRX     = 8'd9;
  localparam logic [7:0] OP_RDX     = 8'd10;
  localparam logic [7:0] OP_SNEMX   = 8'd11;
  localparam logic [7:0] OP_SLTMX   = 8'd12;
  localparam logic [7:0] OP_SETY    = 8'd14;
  localparam logic [7:0] OP_ADDIY   = 8'd15;
  localparam logic [7:0] OP_SUBIY   = 8'd16;
  localparam logic [7:0] OP_WRY     = 8'd17;
  localparam logic [7:0] OP_RDY     = 8'd18;
  localparam logic [7:0] OP_SNEMY   = 8'd19;
  localparam logic [7:0] OP_SLTMY   = 8'd20;
  localparam logic [7:0] OP_SETA    = 8'd22;
  localparam logic [7:0] OP_ADDIA   = 8'd23;
  localparam logic [7:0] OP_SUBIA   = 8'd24;
  localparam logic [7:0] OP_WRA     = 8'd25;
  localparam logic [7:0] OP_RDA     = 8'd26;
  localparam logic [7:0] OP_SNEMA   = 8'd27;
  localparam logic [7:0] OP_SLTMA   = 8'd28;
  localparam logic [7:0] OP_MOVXY   = 8'd30;
  localparam logic [7:0] OP_MOVXA   = 8'd31;
  localparam logic [7:0] OP_MOVYA   = 8'd32;
  localparam logic [7:0] OP_SNEXY   = 8'd33;
  localparam logic [7:0] OP_SLTXY   = 8'd34;
  localparam logic [7:0] OP_SNEXA   = 8'd35;
  localparam logic [7:0] OP_SLTXA   = 8'd36;
  localparam logic [7:0] OP_SNEYA   = 8'd37;
  localparam logic [7:0] OP_SLTYA   = 8'd38;
  localparam logic [7:0] OP_SWPXY   = 8'd39;
  localparam logic [7:0] OP_SWPXA   = 8'd40;
  localparam logic [7:0] OP_SWPYA   = 8'd41;
  localparam logic [7:0] OP_SLTYX   = 8'd42;
  localparam logic [7:0] OP_SLTAX   = 8'd43;
  localparam logic [7:0] OP_SLTAY   = 8'd44;
  localparam logic [7:0] OP_PUSH    = 8'd70;
  localparam logic [7:0] OP_SETSP   = 8'd71;
  localparam logic [7:0] OP_STKX    = 8'd72;
  localparam logic [7:0] OP_STKY    = 8'd73;
  localparam logic [7:0] OP_STKA    = 8'd74;
  localparam logic [7:0] OP_SPX     = 8'd75;
  localparam logic [7:0] OP_SPY     = 8'd76;
  localparam logic [7:0] OP_SPA     = 8'd77;
  localparam logic [7:0] OP_INCX    = 8'd78;
  localparam logic [7:0] OP_DECX    = 8'd79;
  localparam logic [7:0] OP_ADDMX   = 8'd80;
  localparam logic [7:0] OP_SUBMX   = 8'd81;
  localparam logic [7:0] OP_INCY    = 8'd82;
  localparam logic [7:0] OP_DECY    = 8'd83;
  localparam logic [7:0] OP_ADDMY   = 8'd84;
  localparam logic [7:0] OP_SUBMY   = 8'd85;
  localparam logic [7:0] OP_INCA    = 8'd86;
  localparam logic [7:0] OP_DECA    = 8'd87;
  localparam logic [7:0] OP_ADDMA   = 8'd88;
  localparam logic [7:0] OP_SUBMA   = 8'd89;
  localparam logic [7:0] OP_AXY     = 8'd90;
  localparam logic [7:0] OP_AXA     = 8'd91;
  localparam logic [7:0] OP_AYX     = 8'd92;
  localparam logic [7:0] OP_AYA     = 8'd93;
  localparam logic [7:0] OP_AAX     = 8'd94;
  localparam logic [7:0] OP_AAY     = 8'd95;
  localparam logic [7:0] OP_SXY     = 8'd96;
  localparam logic [7:0] OP_SXA     = 8'd97;
  localparam logic [7:0] OP_SYX     = 8'd98;
  localparam logic [7:0] OP_SYA     = 8'd99;
  localparam logic [7:0] OP_SAX     = 8'd100;
  localparam logic [7:0] OP_SAY     = 8'd101;
  localparam logic [7:0] OP_CPYX    = 8'd102;
  localparam logic [7:0] OP_CPYY    = 8'd103;
  localparam logic [7:0] OP_CPYA    = 8'd104;
  localparam logic [7:0] OP_JFWD    = 8'd122;
  localparam logic [7:0] OP_JBACK   = 8'd123;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  a;
    logic [7:0]  sp;
    logic        halt;
  } arch_t;

  typedef struct packed {
    logic                en;
    logic [STACK_AW-1:0] addr;
    logic [15:0]         data;
  } stk_wr_t;

  // Length of console / disk / dump instructions (no effect beyond the counter).
  function automatic logic [1:0] left_out_len(input logic [7:0] op);
    logic [1:0] len;
    len = 2'd1;
    if ((op >= 8'd50 && op <= 8'd52) || (op >= 8'd54 && op <= 8'd56) ||
        op == 8'd66 || (op >= 8'd110 && op <= 8'd112)) begin
      len = 2'd3;
    end else if ((op >= 8'd58 && op <= 8'd65) || (op >= 8'd106 && op <= 8'd108) ||
                 (op >= 8'd114 && op <= 8'd116) || op == 8'd118 || op == 8'd119) begin
      len = 2'd2;
    end
    return len;
  endfunction

endpackage

/* design/acpu_stack.sv */
// Call stack storage: 256 x 16 memory with per-entry valid bits and a
// registered read port with write bypass. Depends on acpu_pkg.
`timescale 1ns / 1ps

module acpu_stack (
  input  logic                           clk,
  input  logic                           rst,
  input  acpu_pkg::stk_wr_t              wr,
  input  logic [acpu_pkg::STACK_AW-1:0]  rd_addr,
  output logic [15:0]                    rd_data
);
  import acpu_pkg::*;

  logic [15:0]            mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] vld;
  logic [15:0]            mem_q;
  logic                   vld_q;
  logic                   hit_q;
  logic [15:0]            byp_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q <= mem[rd_addr];
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
      hit_q <= 1'b1;
      byp_q <= '0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      vld_q <= vld[rd_addr];
      hit_q <= wr.en && (wr.addr == rd_addr);
      byp_q <= wr.data;
    end
  end

  assign rd_data = hit_q ? byp_q : (vld_q ? mem_q : 16'd0);

endmodule

/* design/acpu_exec.sv */
// Instruction execute logic: one instruction against the current
// architectural state, giving next state, stack write and memory write.
// Depends on acpu_pkg.
`timescale 1ns / 1ps

module acpu_exec (
  input  acpu_pkg::arch_t    cur,
  input  logic [7:0]         operation,
  input  logic [7:0]         arg_high,
  input  logic [7:0]         arg_low,
  input  logic [7:0]         mem_data,
  input  logic [15:0]        stack_top,
  output acpu_pkg::arch_t    nxt,
  output acpu_pkg::stk_wr_t  stk_wr,
  output logic               mem_we,
  output logic [14:0]        mem_wa,
  output logic [7:0]         mem_wd,
  output logic [7:0]         fault
);
  import acpu_pkg::*;

  logic [15:0] addr;
  logic [7:0]  sp_dec;
  logic [15:0] pc_base;
  logic [2:0]  adv;
  logic        skip;
  logic        wr;
  logic [7:0]  wsrc;
  logic [7:0]  fault_c;
  arch_t       upd;
  stk_wr_t     swr;

  assign addr   = {arg_high, arg_low};
  assign sp_dec = cur.sp - 8'd1;

  always_comb begin
    upd     = cur;
    pc_base = cur.pc;
    adv     = 3'd0;
    skip    = 1'b0;
    wr      = 1'b0;
    wsrc    = '0;
    fault_c = '0;
    swr     = '0;
    unique case (operation)
      OP_QUIT:  upd.halt = 1'b1;
      OP_EQUIT: begin
        upd.halt = 1'b1;
        fault_c  = arg_high;
      end
      OP_JUMP:  pc_base = addr;
      OP_CALL: begin
        swr.en   = 1'b1;
        swr.addr = cur.sp[STACK_AW-1:0];
        swr.data = cur.pc + 16'd3;
        upd.sp   = cur.sp + 8'd1;
        pc_base  = addr;
      end
      OP_ABORT: begin
        swr.en   = 1'b1;
        swr.addr = sp_dec[STACK_AW-1:0];
        upd.sp   = sp_dec;
        pc_base  = addr;
      end
      OP_RET: begin
        swr.en   = 1'b1;
        swr.addr = sp_dec[STACK_AW-1:0];
        upd.sp   = sp_dec;
        pc_base  = stack_top;
      end
      OP_SETX:  begin upd.x = arg_high;         adv = 3'd2; end
      OP_ADDIX: begin upd.x = cur.x + arg_high; adv = 3'd2; end
      OP_SUBIX: begin upd.x = cur.x - arg_high; adv = 3'd2; end
      OP_WRX:   begin wr = 1'b1; wsrc = cur.x;  adv = 3'd3; end
      OP_RDX:   begin upd.x = mem_data;         adv = 3'd3; end
      OP_SNEMX: begin skip = cur.x != mem_data; adv = 3'd3; end
      OP_SLTMX: begin skip = cur.x < mem_data;  adv = 3'd3; end
      OP_SETY:  begin upd.y = arg_high;         adv = 3'd2; end
      OP_ADDIY: begin upd.y = cur.y + arg_high; adv = 3'd2; end
      OP_SUBIY: begin upd.y = cur.y - arg_high; adv = 3'd2; end
      OP_WRY:   begin wr = 1'b1; wsrc = cur.y;  adv = 3'd3; end
      OP_RDY:   begin upd.y = mem_data;         adv = 3'd3; end
      OP_SNEMY: begin skip = cur.y != mem_data; adv = 3'd3; end
      OP_SLTMY: begin skip = cur.y < mem_data;  adv = 3'd3; end
      OP_SETA:  begin upd.a = arg_high;         adv = 3'd2; end
      OP_ADDIA: begin upd.a = cur.a + arg_high; adv = 3'd2; end
      OP_SUBIA: begin upd.a = cur.a - arg_high; adv = 3'd2; end
      OP_WRA:   begin wr = 1'b1; wsrc = cur.a;  adv = 3'd3; end
      OP_RDA:   begin upd.a = mem_data;         adv = 3'd3; end
      OP_SNEMA: begin skip = cur.a != mem_data; adv = 3'd3; end
      OP_SLTMA: begin skip = cur.a < mem_data;  adv = 3'd3; end
      OP_MOVXY: begin upd.x = cur.y;            adv = 3'd1; end
      OP_MOVXA: begin upd.x = cur.a;            adv = 3'd1; end
      OP_MOVYA: begin upd.y = cur.a;            adv = 3'd1; end
      OP_SNEXY: begin skip = cur.x != cur.y;    adv = 3'd1; end
      OP_SLTXY: begin skip = cur.x < cur.y;     adv = 3'd1; end
      OP_SNEXA: begin skip = cur.x != cur.a;    adv = 3'd1; end
      OP_SLTXA: begin skip = cur.x < cur.a;     adv = 3'd1; end
      OP_SNEYA: begin skip = cur.y != cur.a;    adv = 3'd1; end
      OP_SLTYA: begin skip = cur.y < cur.a;     adv = 3'd1; end
      // swaps also clear the stack entry at the pointer
      OP_SWPXY: begin
        upd.x = cur.y; upd.y = cur.x; adv = 3'd1;
        swr.en = 1'b1; swr.addr = cur.sp[STACK_AW-1:0];
      end
      OP_SWPXA: begin
        upd.x = cur.a; upd.a = cur.x; adv = 3'd1;
        swr.en = 1'b1; swr.addr = cur.sp[STACK_AW-1:0];
      end
      OP_SWPYA: begin
        upd.y = cur.a; upd.a = cur.y; adv = 3'd1;
        swr.en = 1'b1; swr.addr = cur.sp[STACK_AW-1:0];
      end
      OP_SLTYX: begin skip = cur.y < cur.x;     adv = 3'd1; end
      OP_SLTAX: begin skip = cur.a < cur.x;     adv = 3'd1; end
      OP_SLTAY: begin skip = cur.a < cur.y;     adv = 3'd1; end
      OP_PUSH: begin
        swr.en = 1'b1; swr.addr = cur.sp[STACK_AW-1:0]; swr.data = addr;
        upd.sp = cur.sp + 8'd1; adv = 3'd3;
      end
      OP_SETSP: begin upd.sp = arg_high; adv = 3'd2; end
      OP_STKX: begin
        swr.en = 1'b1; swr.addr = cur.x[STACK_AW-1:0]; swr.data = addr; adv = 3'd3;
      end
      OP_STKY: begin
        swr.en = 1'b1; swr.addr = cur.y[STACK_AW-1:0]; swr.data = addr; adv = 3'd3;
      end
      OP_STKA: begin
        swr.en = 1'b1; swr.addr = cur.a[STACK_AW-1:0]; swr.data = addr; adv = 3'd3;
      end
      OP_SPX:   begin upd.sp = cur.x;             adv = 3'd1; end
      OP_SPY:   begin upd.sp = cur.y;             adv = 3'd1; end
      OP_SPA:   begin upd.sp = cur.a;             adv = 3'd1; end
      OP_INCX:  begin upd.x = cur.x + 8'd1;       adv = 3'd1; end
      OP_DECX:  begin upd.x = cur.x - 8'd1;       adv = 3'd1; end
      OP_ADDMX: begin upd.x = cur.x + mem_data;   adv = 3'd3; end
      OP_SUBMX: begin upd.x = cur.x - mem_data;   adv = 3'd3; end
      OP_INCY:  begin upd.y = cur.y + 8'd1;       adv = 3'd1; end
      OP_DECY:  begin upd.y = cur.y - 8'd1;       adv = 3'd1; end
      OP_ADDMY: begin upd.y = cur.y + mem_data;   adv = 3'd3; end
      OP_SUBMY: begin upd.y = cur.y - mem_data;   adv = 3'd3; end
      OP_INCA:  begin upd.a = cur.a + 8'd1;       adv = 3'd1; end
      OP_DECA:  begin upd.a = cur.a - 8'd1;       adv = 3'd1; end
      OP_ADDMA: begin upd.a = cur.a + mem_data;   adv = 3'd3; end
      OP_SUBMA: begin upd.a = cur.a - mem_data;   adv = 3'd3; end
      OP_AXY:   begin upd.x = cur.x + cur.y;      adv = 3'd1; end
      OP_AXA:   begin upd.x = cur.x + cur.a;      adv = 3'd1; end
      OP_AYX:   begin upd.y = cur.y + cur.x;      adv = 3'd1; end
      OP_AYA:   begin upd.y = cur.y + cur.a;      adv = 3'd1; end
      OP_AAX:   begin upd.a = cur.a + cur.x;      adv = 3'd1; end
      OP_AAY:   begin upd.a = cur.a + cur.y;      adv = 3'd1; end
      OP_SXY:   begin upd.x = cur.x - cur.y;      adv = 3'd1; end
      OP_SXA:   begin upd.x = cur.x - cur.a;      adv = 3'd1; end
      OP_SYX:   begin upd.y = cur.y - cur.x;      adv = 3'd1; end
      OP_SYA:   begin upd.y = cur.y - cur.a;      adv = 3'd1; end
      OP_SAX:   begin upd.a = cur.a - cur.x;      adv = 3'd1; end
      OP_SAY:   begin upd.a = cur.a - cur.y;      adv = 3'd1; end
      OP_CPYX:  begin upd.y = cur.x; upd.a = cur.x; adv = 3'd1; end
      OP_CPYY:  begin upd.x = cur.y; upd.a = cur.y; adv = 3'd1; end
      OP_CPYA:  begin upd.x = cur.a; upd.y = cur.a; adv = 3'd1; end
      OP_JFWD:  pc_base = cur.pc + {8'd0, arg_high};
      OP_JBACK: pc_base = cur.pc - {8'd0, arg_high};
      default:  adv = {1'b0, left_out_len(operation)};
    endcase
    if (skip) begin
      adv = adv + SKIP_BYTES;
    end
    upd.pc = pc_base + {13'd0, adv};
  end

  // Halted core holds everything.
  always_comb begin
    if (cur.halt) begin
      nxt    = cur;
      stk_wr = '0;
      mem_we = 1'b0;
      fault  = '0;
    end else begin
      nxt    = upd;
      stk_wr = swr;
      mem_we = wr && !addr[15];
      fault  = fault_c;
    end
  end

  assign mem_wa = mem_we ? addr[14:0] : 15'd0;
  assign mem_wd = mem_we ? wsrc : 8'd0;

endmodule

/* design/accumulator_cpu_execute_core.sv */
// Top level of the accumulator CPU execute core: input register, execute
// logic, call stack and result register. Depends on acpu_pkg, acpu_exec,
// acpu_stack.
`timescale 1ns / 1ps
//
//   channel | handshake            | fields, in order
//   --------+----------------------+---------------------------------------------------------
//   input   | in_valid, in_ready   | operation, arg_high, arg_low, mem_data
//   result  | out_valid, out_ready | program_counter, x/y/a_value, write_*, halted, fault_code
//
// One instruction per clock sustained while out_ready holds; an input beat
// passes through the input register, then the result register, to a result beat.
// The call stack read port is re-read every cycle at the pointer minus one
// of the state the next instruction will see, so a return has its target
// ready in its execute cycle; a same-cycle stack write is bypassed.
// Reset clears the valid flags, the architectural state (pointer and halt flag
// included) and the stack valid bits (entries never written read as zero); no clearing pass is needed.
// A stalled output holds its beat; the input register keeps taking beats
// as long as its content can move into the result register.

module accumulator_cpu_execute_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  operation,
  input  logic [7:0]  arg_high,
  input  logic [7:0]  arg_low,
  input  logic [7:0]  mem_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] program_counter,
  output logic [7:0]  x_value,
  output logic [7:0]  y_value,
  output logic [7:0]  a_value,
  output logic        write_enable,
  output logic [14:0] write_address,
  output logic [7:0]  write_data,
  output logic        halted,
  output logic [7:0]  fault_code
);
  import acpu_pkg::*;

  // input register
  logic        in_full;
  logic [7:0]  op_q;
  logic [7:0]  hi_q;
  logic [7:0]  lo_q;
  logic [7:0]  md_q;

  // architectural state
  arch_t       arch;
  arch_t       arch_next;

  stk_wr_t     stk_wr;
  stk_wr_t     stk_wr_fire;
  logic [15:0] stack_top;
  logic [7:0]  sp_view;
  logic [7:0]  rd_ptr;

  logic        mem_we;
  logic [14:0] mem_wa;
  logic [7:0]  mem_wd;
  logic [7:0]  fault;

  logic        exec_fire;

  // The buffered instruction executes when the result register is free or
  // is being emptied this cycle.
  assign exec_fire = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || exec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (exec_fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q <= operation;
      hi_q <= arg_high;
      lo_q <= arg_low;
      md_q <= mem_data;
    end
  end

  acpu_exec u_exec (
    .cur       (arch),
    .operation (op_q),
    .arg_high  (hi_q),
    .arg_low   (lo_q),
    .mem_data  (md_q),
    .stack_top (stack_top),
    .nxt       (arch_next),
    .stk_wr    (stk_wr),
    .mem_we    (mem_we),
    .mem_wa    (mem_wa),
    .mem_wd    (mem_wd),
    .fault     (fault)
  );

  assign stk_wr_fire = '{en: stk_wr.en && exec_fire, addr: stk_wr.addr, data: stk_wr.data};

  // Pointer the following instruction will see; read one below it.
  assign sp_view = exec_fire ? arch_next.sp : arch.sp;
  assign rd_ptr  = sp_view - 8'd1;

  acpu_stack u_stack (
    .clk     (clk),
    .rst     (rst),
    .wr      (stk_wr_fire),
    .rd_addr (rd_ptr[STACK_AW-1:0]),
    .rd_data (stack_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= '0;
    end else if (exec_fire) begin
      arch <= arch_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      program_counter <= arch_next.pc;
      x_value         <= arch_next.x;
      y_value         <= arch_next.y;
      a_value         <= arch_next.a;
      write_enable    <= mem_we;
      write_address   <= mem_wa;
      write_data      <= mem_wd;
      halted          <= arch_next.halt;
      fault_code      <= fault;
    end
  end

  // Halt is sticky.
  assert property (@(posedge clk) disable iff (rst) arch.halt |=> arch.halt)
    else $error("halt flag dropped without reset");

  // A halted core never touches the stack.
  assert property (@(posedge clk) disable iff (rst) arch.halt |-> !stk_wr_fire.en)
    else $error("stack write while halted");

  // A memory write beat never carries the halt or a fault code.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && write_enable |-> !halted && fault_code == 8'd0)
    else $error("write on a halting beat");

  // A fault code only appears on a halting beat.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && fault_code != 8'd0 |-> halted)
    else $error("fault code without halt");

  // Results are only produced from a buffered instruction.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(in_full))
    else $error("result without instruction");

endmodule
